>>> src/wuf_pkg.sv
// shared types and constants for the weighted union-find engine
`timescale 1ns / 1ps

package wuf_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SIZE_W     = NODE_W + 1;
  localparam int STATUS_W   = 2;

  localparam logic [NODE_W-1:0] ACTIVE_RESET = NODE_W'(NODE_COUNT - 1);

  typedef enum logic [STATUS_W-1:0] {
    RES_JOINED    = 2'd0,
    RES_CONNECTED = 2'd1,
    RES_RANGE     = 2'd2
  } res_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_WR_LOSER,
    ST_WR_WINNER,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    ADDR_IN_A,
    ADDR_B,
    ADDR_PARENT
  } addr_sel_t;

  // one memory word: parent link and size of the tree rooted here
  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [SIZE_W-1:0] size;
  } node_entry_t;

  typedef struct packed {
    logic      clr_we;
    logic      load_in;
    addr_sel_t addr_sel;
    logic      step;
    logic      save_a;
    logic      save_b;
    logic      wr_loser;
    logic      wr_winner;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_err;
    logic root_hit;
    logic same_root;
    logic out_free;
  } dp_sts_t;

endpackage

>>> src/wuf_in_if.sv
// request channel: a pair of nodes to connect
`timescale 1ns / 1ps

interface wuf_in_if import wuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, output node_a, output node_b, input ready);
  modport sink   (input valid, input node_a, input node_b, output ready);
endinterface

>>> src/wuf_out_if.sv
// result channel: status and surviving root
`timescale 1ns / 1ps

interface wuf_out_if import wuf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   root_node;

  modport source (output valid, output status, output root_node, input ready);
  modport sink   (input valid, input status, input root_node, output ready);
endinterface

>>> src/wuf_ctrl.sv
// controller state machine for the union-find engine
`timescale 1ns / 1ps

module wuf_ctrl import wuf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = sts.in_err ? ST_DONE : ST_WALK_A;
      end
      ST_WALK_A: begin
        if (sts.root_hit) state_nxt = ST_WALK_B;
      end
      ST_WALK_B: begin
        if (sts.root_hit) state_nxt = sts.same_root ? ST_DONE : ST_WR_LOSER;
      end
      ST_WR_LOSER:  state_nxt = ST_WR_WINNER;
      ST_WR_WINNER: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ADDR_PARENT;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.addr_sel = ADDR_IN_A;
        cmd.load_in  = in_valid;
      end
      ST_WALK_A: begin
        if (sts.root_hit) begin
          cmd.save_a   = 1'b1;
          cmd.addr_sel = ADDR_B;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_WALK_B: begin
        if (sts.root_hit) begin
          cmd.save_b = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_WR_LOSER:  cmd.wr_loser  = 1'b1;
      ST_WR_WINNER: cmd.wr_winner = 1'b1;
      ST_DONE:      cmd.out_load  = sts.out_free;
      default: ;
    endcase
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == ST_CLEAR)
    else $error("controller not in clear pass after reset");

  a_writes_paired: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR_LOSER |=> state_r == ST_WR_WINNER)
    else $error("loser write not followed by winner write");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_WALK_A || state_r == ST_DONE))
    else $error("accepted beat did not start work");

endmodule

>>> src/wuf_dp.sv
// datapath: node table, root walk registers, merge logic and result stage
`timescale 1ns / 1ps

module wuf_dp import wuf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [NODE_W-1:0]   in_node_a,
  input  logic [NODE_W-1:0]   in_node_b,
  input  logic                cfg_wr_en,
  input  logic [NODE_W-1:0]   cfg_wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [NODE_W-1:0]   out_root_node
);

  node_entry_t node_mem [NODE_COUNT];
  node_entry_t rd_data_r;
  node_entry_t wr_data;
  logic [NODE_W-1:0] rd_addr;
  logic [NODE_W-1:0] wr_addr;
  logic              wr_en;

  logic [NODE_W-1:0] active_r;
  logic [NODE_W-1:0] clr_idx_r;
  logic [NODE_W-1:0] b_r;
  logic [NODE_W-1:0] cur_r;
  logic [NODE_W-1:0] ra_r;
  logic [SIZE_W-1:0] sa_r;
  logic [NODE_W-1:0] winner_r;
  logic [NODE_W-1:0] loser_r;
  logic [SIZE_W-1:0] loser_size_r;
  logic [SIZE_W-1:0] sum_r;
  logic              err_r;
  logic              same_r;
  logic              out_valid_r;
  res_status_t       res_status_r;
  logic [NODE_W-1:0] res_root_r;
  logic              a_smaller;

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_IN_A:   rd_addr = in_node_a;
      ADDR_B:      rd_addr = b_r;
      ADDR_PARENT: rd_addr = rd_data_r.parent;
      default:     rd_addr = rd_data_r.parent;
    endcase
  end

  always_comb begin
    wr_en   = cmd.clr_we | cmd.wr_loser | cmd.wr_winner;
    wr_addr = clr_idx_r;
    wr_data = '{parent: clr_idx_r, size: SIZE_W'(1)};
    if (cmd.wr_loser) begin
      wr_addr = loser_r;
      wr_data = '{parent: winner_r, size: loser_size_r};
    end else if (cmd.wr_winner) begin
      wr_addr = winner_r;
      wr_data = '{parent: winner_r, size: sum_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) node_mem[wr_addr] <= wr_data;
    rd_data_r <= node_mem[rd_addr];
  end

  // during the root walks cur_r names the node whose entry sits in rd_data_r
  assign a_smaller = sa_r < rd_data_r.size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_RESET;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) active_r <= cfg_wr_data;
      if (cmd.clr_we) clr_idx_r <= clr_idx_r + NODE_W'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      b_r   <= in_node_b;
      cur_r <= in_node_a;
      err_r <= sts.in_err;
    end
    if (cmd.step) cur_r <= rd_data_r.parent;
    if (cmd.save_a) begin
      ra_r  <= cur_r;
      sa_r  <= rd_data_r.size;
      cur_r <= b_r;
    end
    if (cmd.save_b) begin
      same_r       <= sts.same_root;
      winner_r     <= a_smaller ? cur_r : ra_r;
      loser_r      <= a_smaller ? ra_r : cur_r;
      loser_size_r <= a_smaller ? sa_r : rd_data_r.size;
      sum_r        <= SIZE_W'(sa_r + rd_data_r.size);
    end
    if (cmd.out_load) begin
      if (err_r) begin
        res_status_r <= RES_RANGE;
        res_root_r   <= '0;
      end else if (same_r) begin
        res_status_r <= RES_CONNECTED;
        res_root_r   <= ra_r;
      end else begin
        res_status_r <= RES_JOINED;
        res_root_r   <= winner_r;
      end
    end
  end

  assign sts.clr_last  = clr_idx_r == NODE_W'(NODE_COUNT - 1);
  assign sts.in_err    = !(in_node_a < active_r) || !(in_node_b < active_r);
  assign sts.root_hit  = rd_data_r.parent == cur_r;
  assign sts.same_root = cur_r == ra_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = res_status_r;
  assign out_root_node = res_root_r;

  a_distinct_roots: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_loser |-> loser_r != winner_r)
    else $error("merge of a root with itself");

  a_size_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_winner |-> sum_r > loser_size_r)
    else $error("merged tree size did not grow");

endmodule

>>> src/weighted_union_find.sv
// out-of-range requests go from the accepting state straight to the result;
// otherwise both nodes are walked to their roots, one memory read per link (depths at
// most 9); only joined pairs then write the loser's and then the winner's entry.
// one request at a time: the next beat can be taken in the cycle after the result is loaded.
// after reset a clearing pass rewrites all 1024 node entries; requests wait.
`timescale 1ns / 1ps

module weighted_union_find import wuf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wuf_in_if.sink            in_ch,
  wuf_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  wuf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wuf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_node_a     (in_ch.node_a),
    .in_node_b     (in_ch.node_b),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_root_node (out_ch.root_node)
  );

endmodule

>>> tb/weighted_union_find_test.sv
// testbench for the weighted union-find engine: predicted results checked beat by beat
`timescale 1ns / 1ps

module weighted_union_find_test;
  import wuf_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;
  localparam int BUILD_BASE  = 700;
  localparam int BUILD_SPAN  = 256;

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    res_status_t status;
    node_t       root;
  } union_verdict_t;

  // shadow copy of the forest; predicts one verdict per accepted pair
  class union_scoreboard;
    node_t             parent [NODE_COUNT];
    logic [SIZE_W-1:0] tree_size [NODE_COUNT];
    node_t             node_limit;
    union_verdict_t    pending [$];
    int                errors;

    function new();
      for (int k = 0; k < NODE_COUNT; k++) begin
        parent[k]    = NODE_W'(k);
        tree_size[k] = SIZE_W'(1);
      end
      node_limit = ACTIVE_RESET;
      errors     = 0;
    endfunction

    function node_t root_of(node_t node);
      node_t cur;
      cur = node;
      for (int hop = 0; hop < NODE_COUNT; hop++) begin
        if (parent[cur] == cur) break;
        cur = parent[cur];
      end
      return cur;
    endfunction

    function void note_request(node_t a, node_t b);
      node_t          ra;
      node_t          rb;
      union_verdict_t v;
      if (a >= node_limit || b >= node_limit) begin
        v.status = RES_RANGE;
        v.root   = '0;
      end else begin
        ra = root_of(a);
        rb = root_of(b);
        if (ra == rb) begin
          v.status = RES_CONNECTED;
          v.root   = ra;
        end else if (tree_size[ra] < tree_size[rb]) begin
          parent[ra]    = rb;
          tree_size[rb] = tree_size[rb] + tree_size[ra];
          v.status      = RES_JOINED;
          v.root        = rb;
        end else begin
          // ties put b's root under a's
          parent[rb]    = ra;
          tree_size[ra] = tree_size[ra] + tree_size[rb];
          v.status      = RES_JOINED;
          v.root        = ra;
        end
      end
      pending.push_back(v);
    endfunction

    task check_result(logic [STATUS_W-1:0] status, node_t root);
      union_verdict_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d root %0d", status, root));
        return;
      end
      want = pending.pop_front();
      if (status != want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (root != want.root)
        report($sformatf("root %0d, want %0d", root, want.root));
    endtask

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  node_t cfg_wr_data;

  wuf_in_if  in_ch ();
  wuf_out_if out_ch ();

  weighted_union_find u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  union_scoreboard sb = new();
  int results_seen = 0;
  int cycles = 0;
  logic calm;

  // a window with no idling on either side
  assign calm = (results_seen >= 400) && (results_seen < 550);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // results first: a beat leaving this edge never belongs to the pair taken at it
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.status, out_ch.root_node);
        results_seen++;
      end
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.node_a, in_ch.node_b);
    end
  end

  // result side: random stalls plus one long hold while pairs keep coming
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= 60) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic send_pair(input node_t a, input node_t b);
    while (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.node_a <= a;
    in_ch.node_b <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // drop valid, wait for every pending verdict, then stay idle as long as extra asks
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_active(input int n);
    settle(4);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= NODE_W'(n);
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    sb.node_limit  = NODE_W'(n);
  endtask

  function automatic void pick_pair(input int n, output node_t a, output node_t b);
    if (n == 0 || $urandom_range(99) < 15) begin
      a = NODE_W'($urandom_range(NODE_COUNT - 1));
      b = NODE_W'($urandom_range(NODE_COUNT - 1));
    end else if (n > 64 && $urandom_range(99) < 40) begin
      // low cluster so large settings still see connected pairs
      a = NODE_W'($urandom_range(63));
      b = NODE_W'($urandom_range(63));
    end else begin
      a = NODE_W'($urandom_range(n - 1));
      if ($urandom_range(99) < 30) begin
        b = a ^ NODE_W'($urandom_range(7));
        if (b >= n) b = a;
      end else begin
        b = NODE_W'($urandom_range(n - 1));
      end
    end
  endfunction

  initial begin
    int    phase_limits [6];
    node_t a;
    node_t b;

    phase_limits = '{16, 1023, 300, 2, 0, 700};
    phase_limits[4] = $urandom_range(1, 1023);

    in_ch.valid  <= 1'b0;
    in_ch.node_a <= '0;
    in_ch.node_b <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of active nodes
    send_pair(10'd0, 10'd0);
    send_pair(10'd1022, 10'd0);
    send_pair(10'd1023, 10'd5);
    send_pair(10'd5, 10'd1023);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd1, 10'd2);
    send_pair(10'd2, 10'd1);
    send_pair(10'd3, 10'd4);
    send_pair(10'd3, 10'd1);
    send_pair(10'd2, 10'd0);
    send_pair(10'd6, 10'd2);
    send_pair(10'd682, 10'd341);
    send_pair(10'd512, 10'd1);

    set_active(0);
    send_pair(10'd0, 10'd0);
    send_pair(10'd5, 10'd9);

    // root 3 lies beyond the shrunk count but is still reported
    set_active(1);
    send_pair(10'd0, 10'd0);
    send_pair(10'd0, 10'd1);
    send_pair(10'd1, 10'd0);

    // balanced merges: every join a tie, depth grows to eight
    set_active(1023);
    for (int s = 1; s < BUILD_SPAN; s = s * 2) begin
      for (int i = 0; i < BUILD_SPAN; i = i + 2 * s)
        send_pair(NODE_W'(BUILD_BASE + i), NODE_W'(BUILD_BASE + i + s));
    end
    for (int k = 0; k < 40; k++)
      send_pair(NODE_W'(BUILD_BASE + $urandom_range(BUILD_SPAN - 1)),
                NODE_W'(BUILD_BASE + $urandom_range(BUILD_SPAN - 1)));

    foreach (phase_limits[p]) begin
      set_active(phase_limits[p]);
      for (int k = 0; k < 100; k++) begin
        pick_pair(phase_limits[p], a, b);
        send_pair(a, b);
      end
    end

    settle(30);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
